/* sv/wrs_pkg.sv */
// Shared types, constants and helper functions for the WAV stream parser.
package wrs_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [1:0]  status;
		logic        is_float;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		logic [15:0] sample_bits;
		logic [31:0] tempo_float_bits;
		logic        tempo_present;
		logic        timeref_present;
		logic [63:0] timeref_samples;
		logic [31:0] data_bytes_total;
	} out_item_t;

	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} push_t;

	typedef enum logic [1:0] {
		PH_ID   = 2'd0,
		PH_SIZE = 2'd1,
		PH_BODY = 2'd2,
		PH_PAD  = 2'd3
	} phase_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_WAVE  = 2'd1;
	localparam logic [1:0] ST_BAD_FMT   = 2'd2;
	localparam logic [1:0] ST_BAD_WIDTH = 2'd3;

	localparam logic        KIND_DATA    = 1'b0;
	localparam logic        KIND_SUMMARY = 1'b1;

	localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;
	localparam logic [31:0] ID_ACID = 32'h6469_6361;
	localparam logic [31:0] ID_BEXT = 32'h7478_6562;

	localparam logic [31:0] TEMPO_LOW  = 32'h41A0_0000;
	localparam logic [31:0] TEMPO_HIGH = 32'h43C8_0000;

	localparam logic [15:0] FMT_PCM        = 16'h0001;
	localparam logic [15:0] FMT_FLOAT      = 16'h0003;
	localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;

	localparam logic [3:0] PREAMBLE_LEN = 4'd12;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	function automatic logic [7:0] riff_wave_byte(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0:    r = 8'h52;
			4'd1:    r = 8'h49;
			4'd2:    r = 8'h46;
			4'd3:    r = 8'h46;
			4'd8:    r = 8'h57;
			4'd9:    r = 8'h41;
			4'd10:   r = 8'h56;
			4'd11:   r = 8'h45;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] guid_rest_byte(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd4:    r = 8'h10;
			4'd6:    r = 8'h80;
			4'd9:    r = 8'haa;
			4'd11:   r = 8'h38;
			4'd12:   r = 8'h9b;
			4'd13:   r = 8'h71;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] put_byte16(input logic [15:0] v, input logic lane,
			input logic [7:0] b);
		return v | ({8'b0, b} << {lane, 3'b000});
	endfunction

	function automatic logic [31:0] put_byte32(input logic [31:0] v, input logic [1:0] lane,
			input logic [7:0] b);
		return v | ({24'b0, b} << {lane, 3'b000});
	endfunction

	function automatic logic [63:0] put_byte64(input logic [63:0] v, input logic [2:0] lane,
			input logic [7:0] b);
		return v | ({56'b0, b} << {lane, 3'b000});
	endfunction

endpackage

/* sv/wrs_parser.sv */
// Chunk walker: holds the parse state and turns one registered byte into its results.
module wrs_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  wrs_pkg::in_item_t  item_s1,
	output wrs_pkg::push_t     push
);

	typedef struct packed {
		logic [3:0]      pre_cnt;
		logic            pre_ok;
		wrs_pkg::phase_t phase;
		logic [1:0]      hidx;
		logic [31:0]     cur_id;
		logic [31:0]     cur_size;
		logic [31:0]     body_off;
		logic [15:0]     fmt_code;
		logic [15:0]     chans;
		logic [31:0]     rate;
		logic [15:0]     bits;
		logic [15:0]     guid_head;
		logic            guid_tail_ok;
		logic [31:0]     tempo_shift;
		logic            tempo_valid;
		logic [31:0]     tempo_bits;
		logic [63:0]     tref_shift;
		logic            tref_valid;
		logic [63:0]     tref_value;
		logic [31:0]     data_size;
	} pstate_t;

	localparam pstate_t PSTATE_RESET = '{pre_ok: 1'b1, phase: wrs_pkg::PH_ID, default: '0};

	pstate_t             st_q;
	pstate_t             st_d;
	logic [7:0]          b;
	logic                eof;
	logic                do_open;
	logic                data_hit;
	logic                match;
	logic                tail_ok;
	logic [31:0]         off;
	logic [31:0]         tempo_new;
	logic [63:0]         tref_new;
	logic [3:0]          gidx;
	logic [2:0]          tlane;
	logic [1:0]          status;
	wrs_pkg::out_item_t  data_item;
	wrs_pkg::out_item_t  summary;

	assign b   = item_s1.in_byte;
	assign eof = item_s1.end_of_file;
	assign off = st_q.body_off;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PSTATE_RESET;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		do_open   = 1'b0;
		data_hit  = 1'b0;
		match     = 1'b0;
		tail_ok   = 1'b0;
		tempo_new = st_q.tempo_shift;
		tref_new  = st_q.tref_shift;
		gidx      = off[3:0] - 4'd10;
		tlane     = off[2:0] - 3'd2;
		status    = wrs_pkg::ST_OK;
		summary   = '0;
		data_item = '0;
		push      = '0;

		if (step) begin
			if (st_q.pre_cnt < wrs_pkg::PREAMBLE_LEN) begin
				if ((st_q.pre_cnt < 4'd4 || st_q.pre_cnt >= 4'd8) &&
						b != wrs_pkg::riff_wave_byte(st_q.pre_cnt)) begin
					st_d.pre_ok = 1'b0;
				end
				st_d.pre_cnt = st_q.pre_cnt + 4'd1;
			end else if (st_q.pre_ok) begin
				case (st_q.phase)
					wrs_pkg::PH_ID: begin
						st_d.cur_id = (st_q.hidx == 2'd0) ? {24'b0, b} :
							wrs_pkg::put_byte32(st_q.cur_id, st_q.hidx, b);
						if (st_q.hidx == 2'd3) begin
							st_d.hidx     = 2'd0;
							st_d.cur_size = '0;
							st_d.phase    = wrs_pkg::PH_SIZE;
						end else begin
							st_d.hidx = st_q.hidx + 2'd1;
						end
					end
					wrs_pkg::PH_SIZE: begin
						st_d.cur_size = (st_q.hidx == 2'd0) ? {24'b0, b} :
							wrs_pkg::put_byte32(st_q.cur_size, st_q.hidx, b);
						if (st_q.hidx == 2'd3) begin
							st_d.hidx     = 2'd0;
							do_open       = 1'b1;
							st_d.body_off = '0;
							st_d.phase    = (st_d.cur_size == 32'd0) ? wrs_pkg::PH_ID :
								wrs_pkg::PH_BODY;
						end else begin
							st_d.hidx = st_q.hidx + 2'd1;
						end
					end
					wrs_pkg::PH_BODY: begin
						if (st_q.cur_id == wrs_pkg::ID_DATA) begin
							data_hit = 1'b1;
						end else if (st_q.cur_id == wrs_pkg::ID_FMT &&
								st_q.cur_size >= 32'd16) begin
							if (off < 32'd2) begin
								st_d.fmt_code = wrs_pkg::put_byte16(st_q.fmt_code, off[0], b);
							end else if (off < 32'd4) begin
								st_d.chans = wrs_pkg::put_byte16(st_q.chans, off[0], b);
							end else if (off < 32'd8) begin
								st_d.rate = wrs_pkg::put_byte32(st_q.rate, off[1:0], b);
							end else if (off == 32'd14 || off == 32'd15) begin
								st_d.bits = wrs_pkg::put_byte16(st_q.bits, off[0], b);
							end else if (off == 32'd24 || off == 32'd25) begin
								st_d.guid_head = wrs_pkg::put_byte16(st_q.guid_head, off[0], b);
							end else if (off >= 32'd26 && off <= 32'd39) begin
								match   = (b == wrs_pkg::guid_rest_byte(gidx));
								tail_ok = (off == 32'd26) ? match : (st_q.guid_tail_ok & match);
								st_d.guid_tail_ok = tail_ok;
								if (off == 32'd39 && st_q.cur_size >= 32'd40 &&
										st_q.fmt_code == wrs_pkg::FMT_EXTENSIBLE && tail_ok) begin
									if (st_q.guid_head == wrs_pkg::FMT_PCM) begin
										st_d.fmt_code = wrs_pkg::FMT_PCM;
									end else if (st_q.guid_head == wrs_pkg::FMT_FLOAT) begin
										st_d.fmt_code = wrs_pkg::FMT_FLOAT;
									end
								end
							end
						end else if (st_q.cur_id == wrs_pkg::ID_ACID) begin
							if (off >= 32'd16 && off <= 32'd19) begin
								tempo_new = wrs_pkg::put_byte32(st_q.tempo_shift, off[1:0], b);
								st_d.tempo_shift = tempo_new;
								if (off == 32'd19 && st_q.cur_size >= 32'd24 &&
										tempo_new >= wrs_pkg::TEMPO_LOW &&
										tempo_new <= wrs_pkg::TEMPO_HIGH) begin
									st_d.tempo_valid = 1'b1;
									st_d.tempo_bits  = tempo_new;
								end
							end
						end else if (st_q.cur_id == wrs_pkg::ID_BEXT &&
								st_q.cur_size >= 32'd346) begin
							if (off >= 32'd338 && off <= 32'd345) begin
								tref_new = wrs_pkg::put_byte64(st_q.tref_shift, tlane, b);
								st_d.tref_shift = tref_new;
								st_d.tref_value = tref_new;
							end
						end
						if (off == st_q.cur_size - 32'd1) begin
							st_d.phase = st_q.cur_size[0] ? wrs_pkg::PH_PAD : wrs_pkg::PH_ID;
						end else begin
							st_d.body_off = off + 32'd1;
						end
					end
					default: begin
						st_d.phase = wrs_pkg::PH_ID;
					end
				endcase
			end

			if (eof && st_d.pre_cnt >= wrs_pkg::PREAMBLE_LEN && st_d.pre_ok &&
					st_d.phase == wrs_pkg::PH_SIZE) begin
				do_open = 1'b1;
			end

			if (do_open) begin
				if (st_d.cur_id == wrs_pkg::ID_FMT && st_d.cur_size >= 32'd16) begin
					st_d.fmt_code     = '0;
					st_d.chans        = '0;
					st_d.rate         = '0;
					st_d.bits         = '0;
					st_d.guid_head    = '0;
					st_d.guid_tail_ok = 1'b0;
				end else if (st_d.cur_id == wrs_pkg::ID_DATA) begin
					st_d.data_size = st_d.cur_size;
				end else if (st_d.cur_id == wrs_pkg::ID_ACID) begin
					st_d.tempo_shift = '0;
				end else if (st_d.cur_id == wrs_pkg::ID_BEXT && st_d.cur_size >= 32'd346) begin
					st_d.tref_shift = '0;
					st_d.tref_valid = 1'b1;
					st_d.tref_value = '0;
				end
			end

			if (st_d.pre_cnt < wrs_pkg::PREAMBLE_LEN || !st_d.pre_ok) begin
				status = wrs_pkg::ST_NOT_WAVE;
			end else if ((st_d.fmt_code != wrs_pkg::FMT_PCM &&
					st_d.fmt_code != wrs_pkg::FMT_FLOAT) || st_d.chans == 16'd0 ||
					st_d.rate == 32'd0 || st_d.data_size == 32'd0) begin
				status = wrs_pkg::ST_BAD_FMT;
			end else if ((st_d.fmt_code == wrs_pkg::FMT_PCM) ?
					(st_d.bits != 16'd16 && st_d.bits != 16'd24 && st_d.bits != 16'd32) :
					(st_d.bits != 16'd32 && st_d.bits != 16'd64)) begin
				status = wrs_pkg::ST_BAD_WIDTH;
			end

			summary.kind             = wrs_pkg::KIND_SUMMARY;
			summary.status           = status;
			summary.is_float         = (st_d.fmt_code == wrs_pkg::FMT_FLOAT);
			summary.channel_count    = st_d.chans;
			summary.rate_hz          = st_d.rate;
			summary.sample_bits      = st_d.bits;
			summary.tempo_float_bits = st_d.tempo_valid ? st_d.tempo_bits : 32'd0;
			summary.tempo_present    = st_d.tempo_valid;
			summary.timeref_present  = st_d.tref_valid;
			summary.timeref_samples  = st_d.tref_valid ? st_d.tref_value : 64'd0;
			summary.data_bytes_total = st_d.data_size;

			data_item.kind      = wrs_pkg::KIND_DATA;
			data_item.data_byte = b;

			if (data_hit) begin
				push.first  = data_item;
				push.second = summary;
				push.count  = eof ? 2'd2 : 2'd1;
			end else begin
				push.first  = summary;
				push.count  = eof ? 2'd1 : 2'd0;
			end

			if (eof) begin
				st_d = PSTATE_RESET;
			end
		end
	end

endmodule

/* sv/wrs_result_fifo.sv */
// Result queue: takes up to two results per cycle and delivers one per transfer.
module wrs_result_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  wrs_pkg::push_t     push,
	output logic               room,
	output logic               result_valid,
	input  logic               result_stall,
	output wrs_pkg::out_item_t result_item
);

	wrs_pkg::out_item_t           mem [wrs_pkg::FIFO_DEPTH];
	logic [wrs_pkg::FIFO_AW-1:0]  wr_q;
	logic [wrs_pkg::FIFO_AW-1:0]  rd_q;
	logic [wrs_pkg::FIFO_AW:0]    count_q;
	logic                         pop;

	assign result_valid = (count_q != '0);
	assign result_item  = mem[rd_q];
	assign pop          = result_valid & ~result_stall;
	assign room         = (count_q <= (wrs_pkg::FIFO_AW+1)'(wrs_pkg::FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem[wr_q + 1'b1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + wrs_pkg::FIFO_AW'(push.count);
			rd_q    <= rd_q + wrs_pkg::FIFO_AW'(pop);
			count_q <= count_q + (wrs_pkg::FIFO_AW+1)'(push.count)
				- (wrs_pkg::FIFO_AW+1)'(pop);
		end
	end

endmodule

/* sv/wav_riff_stream_parser.sv */
// Top level of the WAV stream parser: input register, chunk walker and result queue.
//
//   channel   direction  handshake               payload
//   byte      in         byte_valid/byte_stall   wrs_pkg::in_item_t   byte_item
//   result    out        result_valid/result_stall wrs_pkg::out_item_t result_item
//
// A byte is taken at every edge unless the input register holds a byte the queue has no room for.
// Each byte is held in the input register until the queue has room, then parsed into the result
// queue, from which its result is presented and can transfer out.
// A data body byte that ends the file yields two results and takes two queue slots.
// Reset returns the parser to the start of a file and empties the queue.
// When the four-entry queue holds more than two results, a waiting byte stalls the byte side.
module wav_riff_stream_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  wrs_pkg::in_item_t  byte_item,
	output logic               result_valid,
	input  logic               result_stall,
	output wrs_pkg::out_item_t result_item
);

	logic               valid_s1;
	wrs_pkg::in_item_t  item_s1;
	logic               room;
	logic               step;
	wrs_pkg::push_t     push;

	assign step       = valid_s1 & room;
	assign byte_stall = valid_s1 & ~room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	wrs_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item_s1 (item_s1),
		.push    (push)
	);

	wrs_result_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule
